// ===== sv/pol_pkg.sv =====
// Shared command and status codes for the positional ordered list.
`timescale 1ns / 1ps

package pol_pkg;

    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_POS   = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_BACK  = 3'd4,
        CMD_DEL_POS   = 3'd5,
        CMD_READ_ALL  = 3'd6
    } command_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    localparam int DATA_W = 32;

endpackage

// ===== sv/pol_mem.sv =====
// Entry storage: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module pol_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // hold the last read word until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/positional_ordered_list_core.sv =====
// Edits: an insert moves each entry above the slot up by a read and a write (S_INS_RD,
// S_INS_WR), then writes the value (S_INS_PUT); a delete moves the entries down likewise.
// Read-all: each result item is one read of the single read port of the entry memory.
// One item is worked at a time; a new item is taken while the last result still waits.
// Reset (rst_n low, asynchronous) empties the list; memory contents are left as they are.
// Top level: sequencer, entry memory and output register of the positional ordered list.
`timescale 1ns / 1ps

module positional_ordered_list_core #(
    parameter int CAPACITY = 16,
    localparam int CNT_W = $clog2(CAPACITY + 1),
    localparam int POS_W = $clog2(CAPACITY + 2)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           command,
    input  logic signed [31:0]   value,
    input  logic [POS_W-1:0]     position,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic signed [31:0]   entry_value,
    output logic                 is_last,
    output logic [CNT_W-1:0]     entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int DW = pol_pkg::DATA_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_DEL_RD,
        S_DEL_WR,
        S_EMIT,
        S_RD_REQ,
        S_RD_OUT
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [AW-1:0]       ptr_reg;
    logic [AW-1:0]       idx_reg;
    logic [DW-1:0]       val_reg;
    pol_pkg::status_t    pend_reg;
    logic                out_valid_reg;
    pol_pkg::status_t    out_status_reg;
    logic [DW-1:0]       out_value_reg;
    logic                out_last_reg;
    logic [CNT_W-1:0]    out_count_reg;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [DW-1:0]       mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [DW-1:0]       mem_rdata;

    pol_pkg::command_t   cmd;
    logic [POS_W:0]      pos_x;
    logic [POS_W:0]      cnt_x;
    logic                ins_pos_ok;
    logic                del_pos_ok;
    logic                is_full;
    logic                is_empty;
    logic [AW-1:0]       ins_idx;
    logic [AW-1:0]       del_idx;
    logic                slot_free;
    logic                out_load;
    logic                rd_last;

    pol_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign slot_free = !out_valid_reg || out_ready;
    assign out_load  = slot_free && ((state_reg == S_EMIT) || (state_reg == S_RD_OUT));
    assign rd_last   = ((CNT_W'(ptr_reg) + CNT_W'(1)) == count_reg);

    // decode of the incoming item
    always_comb
    begin
        cmd        = pol_pkg::command_t'(command);
        pos_x      = {1'b0, position};
        cnt_x      = (POS_W + 1)'(count_reg);
        ins_pos_ok = (pos_x != '0) && (pos_x <= cnt_x + (POS_W + 1)'(1));
        del_pos_ok = (pos_x != '0) && (pos_x <= cnt_x);
        is_full    = (count_reg == CNT_W'(CAPACITY));
        is_empty   = (count_reg == '0);
        case (cmd)
            pol_pkg::CMD_INS_FRONT: ins_idx = '0;
            pol_pkg::CMD_INS_BACK:  ins_idx = AW'(count_reg);
            default:                ins_idx = AW'(position - POS_W'(1));
        endcase
        case (cmd)
            pol_pkg::CMD_DEL_FRONT: del_idx = '0;
            pol_pkg::CMD_DEL_BACK:  del_idx = AW'(count_reg - CNT_W'(1));
            default:                del_idx = AW'(position - POS_W'(1));
        endcase
    end

    // memory port control
    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = ptr_reg;
        mem_we    = 1'b0;
        mem_waddr = ptr_reg;
        mem_wdata = mem_rdata;
        case (state_reg)
            S_INS_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = ptr_reg - AW'(1);
            end
            S_INS_WR:
            begin
                mem_we = 1'b1;
            end
            S_INS_PUT:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = val_reg;
            end
            S_DEL_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = ptr_reg + AW'(1);
            end
            S_DEL_WR:
            begin
                mem_we = 1'b1;
            end
            S_RD_REQ:
            begin
                mem_re = 1'b1;
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            ptr_reg        <= '0;
            idx_reg        <= '0;
            val_reg        <= '0;
            pend_reg       <= pol_pkg::ST_OK;
            out_valid_reg  <= 1'b0;
            out_status_reg <= pol_pkg::ST_OK;
            out_value_reg  <= '0;
            out_last_reg   <= 1'b0;
            out_count_reg  <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        case (cmd)
                            pol_pkg::CMD_INS_FRONT,
                            pol_pkg::CMD_INS_BACK,
                            pol_pkg::CMD_INS_POS:
                            begin
                                val_reg <= value;
                                if (is_full)
                                begin
                                    pend_reg  <= pol_pkg::ST_FULL;
                                    state_reg <= S_EMIT;
                                end
                                else if (cmd == pol_pkg::CMD_INS_POS && !ins_pos_ok)
                                begin
                                    pend_reg  <= pol_pkg::ST_RANGE;
                                    state_reg <= S_EMIT;
                                end
                                else
                                begin
                                    idx_reg <= ins_idx;
                                    ptr_reg <= AW'(count_reg);
                                    if (CNT_W'(ins_idx) < count_reg)
                                    begin
                                        state_reg <= S_INS_RD;
                                    end
                                    else
                                    begin
                                        state_reg <= S_INS_PUT;
                                    end
                                end
                            end
                            pol_pkg::CMD_DEL_FRONT,
                            pol_pkg::CMD_DEL_BACK,
                            pol_pkg::CMD_DEL_POS:
                            begin
                                if (is_empty)
                                begin
                                    pend_reg  <= pol_pkg::ST_EMPTY;
                                    state_reg <= S_EMIT;
                                end
                                else if (cmd == pol_pkg::CMD_DEL_POS && !del_pos_ok)
                                begin
                                    pend_reg  <= pol_pkg::ST_RANGE;
                                    state_reg <= S_EMIT;
                                end
                                else
                                begin
                                    ptr_reg <= del_idx;
                                    if ((CNT_W'(del_idx) + CNT_W'(1)) < count_reg)
                                    begin
                                        state_reg <= S_DEL_RD;
                                    end
                                    else
                                    begin
                                        count_reg <= count_reg - CNT_W'(1);
                                        pend_reg  <= pol_pkg::ST_OK;
                                        state_reg <= S_EMIT;
                                    end
                                end
                            end
                            pol_pkg::CMD_READ_ALL:
                            begin
                                if (is_empty)
                                begin
                                    pend_reg  <= pol_pkg::ST_EMPTY;
                                    state_reg <= S_EMIT;
                                end
                                else
                                begin
                                    ptr_reg   <= '0;
                                    state_reg <= S_RD_REQ;
                                end
                            end
                            default:
                            begin
                                // unused code: drop the item
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_INS_RD:
                begin
                    state_reg <= S_INS_WR;
                end
                S_INS_WR:
                begin
                    // move one entry up, walking toward the insert slot
                    ptr_reg <= ptr_reg - AW'(1);
                    if ((ptr_reg - AW'(1)) > idx_reg)
                    begin
                        state_reg <= S_INS_RD;
                    end
                    else
                    begin
                        state_reg <= S_INS_PUT;
                    end
                end
                S_INS_PUT:
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    pend_reg  <= pol_pkg::ST_OK;
                    state_reg <= S_EMIT;
                end
                S_DEL_RD:
                begin
                    state_reg <= S_DEL_WR;
                end
                S_DEL_WR:
                begin
                    ptr_reg <= ptr_reg + AW'(1);
                    if ((CNT_W'(ptr_reg) + CNT_W'(2)) < count_reg)
                    begin
                        state_reg <= S_DEL_RD;
                    end
                    else
                    begin
                        count_reg <= count_reg - CNT_W'(1);
                        pend_reg  <= pol_pkg::ST_OK;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_status_reg <= pend_reg;
                        out_value_reg  <= '0;
                        out_last_reg   <= 1'b1;
                        out_count_reg  <= count_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                S_RD_REQ:
                begin
                    state_reg <= S_RD_OUT;
                end
                S_RD_OUT:
                begin
                    if (slot_free)
                    begin
                        out_status_reg <= pol_pkg::ST_OK;
                        out_value_reg  <= mem_rdata;
                        out_last_reg   <= rd_last;
                        out_count_reg  <= count_reg;
                        if (rd_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            ptr_reg   <= ptr_reg + AW'(1);
                            state_reg <= S_RD_REQ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign entry_value = out_value_reg;
    assign is_last     = out_last_reg;
    assign entry_count = out_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CNT_W'(1)) ||
            (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("entry count moved by more than one");

    a_error_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != pol_pkg::ST_OK) |->
            (out_last_reg && out_value_reg == '0))
        else $error("error result not final or carries data");

endmodule

// ===== tb/sv/positional_ordered_list_core_tb.sv =====
// Self-checking testbench for the positional ordered list core.
`timescale 1ns / 1ps

module positional_ordered_list_core_tb;

    localparam int LIST_CAP = 16;
    localparam int RANDOM_ITEMS = 380;
    localparam int PHASE_ITEMS = 40;
    localparam int LONG_HOLD = 400;
    localparam int SETTLE_CYCLES = 80;
    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

    // Mirror of the list contents; predicts the result items of each accepted command.
    class list_mirror;
        typedef struct {
            pol_pkg::status_t   st;
            logic signed [31:0] val;
            logic               last;
            logic [4:0]         cnt;
        } list_result_t;

        logic signed [31:0] slots[LIST_CAP];
        int                 fill;
        int                 peak_fill;
        int                 errors;
        int                 checked;
        int                 status_hits[4];
        list_result_t       pending_results[$];

        function new();
            fill = 0;
            peak_fill = 0;
            errors = 0;
            checked = 0;
            foreach (status_hits[i])
                status_hits[i] = 0;
        endfunction

        function void push(pol_pkg::status_t st, logic signed [31:0] val, logic last);
            list_result_t r;
            r.st = st;
            r.val = val;
            r.last = last;
            r.cnt = fill[4:0];
            pending_results.push_back(r);
        endfunction

        function void insert_slot(int idx, logic signed [31:0] v);
            for (int i = fill; i > idx; i--)
                slots[i] = slots[i - 1];
            slots[idx] = v;
            fill++;
            if (fill > peak_fill)
                peak_fill = fill;
        endfunction

        function void remove_slot(int idx);
            for (int i = idx; i + 1 < fill; i++)
                slots[i] = slots[i + 1];
            fill--;
        endfunction

        function void note_command(logic [2:0] cmd, logic signed [31:0] v, logic [4:0] pos);
            pol_pkg::status_t st;
            st = pol_pkg::ST_OK;
            case (cmd)
                pol_pkg::CMD_INS_FRONT, pol_pkg::CMD_INS_BACK, pol_pkg::CMD_INS_POS:
                begin
                    // full is checked ahead of the position
                    if (fill >= LIST_CAP)
                        st = pol_pkg::ST_FULL;
                    else if (cmd == pol_pkg::CMD_INS_FRONT)
                        insert_slot(0, v);
                    else if (cmd == pol_pkg::CMD_INS_BACK)
                        insert_slot(fill, v);
                    else if (pos < 1 || pos > fill + 1)
                        st = pol_pkg::ST_RANGE;
                    else
                        insert_slot(pos - 1, v);
                end
                pol_pkg::CMD_DEL_FRONT, pol_pkg::CMD_DEL_BACK, pol_pkg::CMD_DEL_POS:
                begin
                    if (fill == 0)
                        st = pol_pkg::ST_EMPTY;
                    else if (cmd == pol_pkg::CMD_DEL_FRONT)
                        remove_slot(0);
                    else if (cmd == pol_pkg::CMD_DEL_BACK)
                        remove_slot(fill - 1);
                    else if (pos < 1 || pos > fill)
                        st = pol_pkg::ST_RANGE;
                    else
                        remove_slot(pos - 1);
                end
                pol_pkg::CMD_READ_ALL:
                begin
                    if (fill == 0)
                        push(pol_pkg::ST_EMPTY, '0, 1'b1);
                    else
                        for (int i = 0; i < fill; i++)
                            push(pol_pkg::ST_OK, slots[i], i == fill - 1);
                    return;
                end
                default:
                    return;
            endcase
            push(st, '0, 1'b1);
        endfunction

        function void check_result(logic [1:0] st, logic signed [31:0] val, logic last,
                                   logic [4:0] cnt);
            list_result_t exp;
            checked++;
            status_hits[st]++;
            if (pending_results.size() == 0)
            begin
                $error("result item with nothing pending: status %0d value %0d", st, val);
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            if (st !== exp.st)
            begin
                $error("status: expected %0d, got %0d", exp.st, st);
                errors++;
            end
            if (val !== exp.val)
            begin
                $error("entry_value: expected %0d, got %0d", exp.val, val);
                errors++;
            end
            if (last !== exp.last)
            begin
                $error("is_last: expected %0d, got %0d", exp.last, last);
                errors++;
            end
            if (cnt !== exp.cnt)
            begin
                $error("entry_count: expected %0d, got %0d", exp.cnt, cnt);
                errors++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [2:0]          command = 3'd0;
    logic signed [31:0]  value = '0;
    logic [4:0]          position = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [1:0]          status;
    logic signed [31:0]  entry_value;
    logic                is_last;
    logic [4:0]          entry_count;

    bit                  no_idle = 1'b0;
    bit                  hold_request = 1'b0;
    int                  sent = 0;
    list_mirror          mirror = new();

    positional_ordered_list_core #(.CAPACITY(LIST_CAP)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .value       (value),
        .position    (position),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .entry_value (entry_value),
        .is_last     (is_last),
        .entry_count (entry_count)
    );

    initial
    begin
        forever
            #2 clk = ~clk;
    end

    initial
    begin
        #6_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Hold valid and payload until the item is taken; lower valid only across a gap.
    task automatic offer_command(input logic [2:0] cmd, input logic signed [31:0] v,
                                 input logic [4:0] pos);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        value <= v;
        position <= pos;
        do
            @(posedge clk);
        while (!in_ready);
        mirror.note_command(cmd, v, pos);
        if (cmd != CMD_UNUSED)
            sent++;
    endtask

    task automatic offer_random(input bit grow);
        int r;
        logic [2:0] cmd;
        logic signed [31:0] v;
        logic [4:0] pos;
        r = $urandom_range(0, 99);
        if (r < 3)
            cmd = CMD_UNUSED;
        else if (r < 11)
            cmd = pol_pkg::CMD_READ_ALL;
        else if (r < (grow ? 80 : 35))
            cmd = 3'($urandom_range(pol_pkg::CMD_INS_FRONT, pol_pkg::CMD_INS_POS));
        else
            cmd = 3'($urandom_range(pol_pkg::CMD_DEL_FRONT, pol_pkg::CMD_DEL_POS));
        case ($urandom_range(0, 9))
            0: v = VAL_MIN;
            1: v = VAL_MAX;
            2: v = ($urandom_range(0, 1) != 0) ? 32'sd0 : -32'sd1;
            default: v = $urandom;
        endcase
        // mostly in range, the rest anywhere in the field
        if ($urandom_range(0, 3) == 0)
            pos = 5'($urandom_range(0, 31));
        else if (cmd == pol_pkg::CMD_INS_POS)
            pos = 5'($urandom_range(1, mirror.fill + 1));
        else
            pos = 5'($urandom_range(1, (mirror.fill > 0) ? mirror.fill : 1));
        offer_command(cmd, v, pos);
    endtask

    // Receiver: random ready pattern, long hold-off when asked.
    initial
    begin
        int  stretch;
        int  gap;
        bit  level;
        stretch = 0;
        level = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                level = 1'b0;
                stretch = LONG_HOLD;
            end
            else if (stretch == 0)
            begin
                gap = pick_gap();
                if (!level || gap == 0)
                begin
                    level = 1'b1;
                    stretch = $urandom_range(1, 24);
                end
                else
                begin
                    level = 1'b0;
                    stretch = gap;
                end
            end
            out_ready <= level;
            stretch--;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            mirror.check_result(status, entry_value, is_last, entry_count);
    end

    initial
    begin
        int guard;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list, range edges, extremes, only-entry delete, unused code
        offer_command(pol_pkg::CMD_READ_ALL, '0, 5'd0);
        offer_command(pol_pkg::CMD_DEL_FRONT, '0, 5'd1);
        offer_command(pol_pkg::CMD_DEL_BACK, '0, 5'd1);
        offer_command(pol_pkg::CMD_DEL_POS, '0, 5'd1);
        offer_command(pol_pkg::CMD_INS_POS, 32'sd5, 5'd0);
        offer_command(pol_pkg::CMD_INS_POS, 32'sd6, 5'd2);
        offer_command(pol_pkg::CMD_INS_POS, VAL_MAX, 5'd1);
        offer_command(pol_pkg::CMD_DEL_POS, '0, 5'd1);
        offer_command(pol_pkg::CMD_INS_FRONT, VAL_MIN, 5'd31);
        offer_command(pol_pkg::CMD_INS_BACK, -32'sd1, 5'd0);
        offer_command(pol_pkg::CMD_INS_POS, 32'sd0, 5'd3);
        offer_command(pol_pkg::CMD_INS_POS, 32'sh5555_5555, 5'd2);
        offer_command(pol_pkg::CMD_READ_ALL, 32'shAAAA_AAAA, 5'd31);
        offer_command(pol_pkg::CMD_DEL_POS, '0, 5'd0);
        offer_command(pol_pkg::CMD_DEL_POS, '0, 5'd5);
        offer_command(pol_pkg::CMD_DEL_POS, '0, 5'd31);
        offer_command(pol_pkg::CMD_INS_POS, 32'sd9, 5'd31);
        offer_command(CMD_UNUSED, 32'sd7, 5'd7);
        offer_command(pol_pkg::CMD_DEL_POS, '0, 5'd2);
        offer_command(pol_pkg::CMD_DEL_BACK, '0, 5'd0);
        offer_command(pol_pkg::CMD_DEL_FRONT, '0, 5'd0);
        offer_command(pol_pkg::CMD_READ_ALL, '0, 5'd0);
        offer_command(pol_pkg::CMD_DEL_FRONT, '0, 5'd0);
        offer_command(pol_pkg::CMD_READ_ALL, '0, 5'd0);

        // random: alternate filling and draining so the list swings between empty and full
        sent = 0;
        for (int phase = 0; sent < RANDOM_ITEMS; phase++)
        begin
            no_idle = (phase % 5 == 3);
            if (phase == 2)
                hold_request = 1'b1;
            if (phase == 5)
            begin
                // drain everything before going on
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (mirror.pending_results.size() != 0);
            end
            for (int k = 0; k < PHASE_ITEMS && sent < RANDOM_ITEMS; k++)
                offer_random(phase % 2 == 0);
        end
        no_idle = 1'b0;

        in_valid <= 1'b0;
        guard = 0;
        while (mirror.pending_results.size() != 0 && guard < 50_000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mirror.pending_results.size() != 0)
        begin
            $error("%0d result items never arrived", mirror.pending_results.size());
            mirror.errors++;
        end

        $display("Run: %0d random commands plus directed edits, %0d result items checked.",
                 sent, mirror.checked);
        $display("Statuses ok/empty/full/range: %0d/%0d/%0d/%0d, peak fill %0d of %0d.",
                 mirror.status_hits[pol_pkg::ST_OK], mirror.status_hits[pol_pkg::ST_EMPTY],
                 mirror.status_hits[pol_pkg::ST_FULL], mirror.status_hits[pol_pkg::ST_RANGE],
                 mirror.peak_fill, LIST_CAP);
        if (mirror.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
